FILE: rtl/scp_pkg.sv
// shared constants and types for the segment closest points unit
`default_nettype none

package scp_pkg;

  localparam int SCP_COORD_WIDTH = 32;
  localparam int SCP_FRAC_BITS   = 16;
  localparam int SCP_MUL_CHUNK   = 17;

  // how the final quotient turns into an output value
  typedef enum logic [1:0] {
    KIND_ZERO,
    KIND_ONE,
    KIND_RATIO,
    KIND_RAW
  } scp_kind_t;

endpackage

`default_nettype wire

FILE: rtl/scp_mul.sv
// pipelined signed multiplier, one chunk of the second operand per stage
`default_nettype none

module scp_mul import scp_pkg::*; #(
  parameter int AW  = 68,
  parameter int BW  = 68,
  parameter int CHW = SCP_MUL_CHUNK
) (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic signed [AW-1:0] a,
  input  wire logic signed [BW-1:0] b,
  output logic signed [AW+BW-1:0]   p
);

  localparam int NCH = (BW + CHW - 1) / CHW;
  localparam int BXW = NCH * CHW;
  localparam int PW  = AW + BW;

  logic signed [AW-1:0]  a_r   [NCH-1];
  logic signed [BXW-1:0] b_r   [NCH-1];
  logic signed [PW-1:0]  acc_r [NCH];

  for (genvar k = 0; k < NCH; k++) begin : g_stage
    logic signed [AW-1:0]  a_in;
    logic signed [BXW-1:0] b_in;
    logic signed [PW-1:0]  acc_in;
    logic signed [CHW:0]   chunk;
    logic signed [AW+CHW:0] pp;
    logic signed [PW-1:0]  acc_nxt;

    if (k == 0) begin : g_first
      assign a_in   = a;
      assign b_in   = BXW'(b);
      assign acc_in = '0;
    end else begin : g_next
      assign a_in   = a_r[k-1];
      assign b_in   = b_r[k-1];
      assign acc_in = acc_r[k-1];
    end

    // top chunk carries the sign, lower chunks are unsigned
    if (k == NCH - 1) begin : g_top
      assign chunk = {b_in[BXW-1], b_in[k*CHW +: CHW]};
    end else begin : g_low
      assign chunk = {1'b0, b_in[k*CHW +: CHW]};
      always_ff @(posedge clk) begin
        if (en) begin
          a_r[k] <= a_in;
          b_r[k] <= b_in;
        end
      end
    end

    assign pp      = a_in * chunk;
    assign acc_nxt = acc_in + (PW'(pp) <<< (k * CHW));

    always_ff @(posedge clk) begin
      if (en) begin
        acc_r[k] <= acc_nxt;
      end
    end
  end

  assign p = acc_r[NCH-1];

endmodule

`default_nettype wire

FILE: rtl/scp_div.sv
// pipelined restoring divider, one quotient bit per stage, with sideband
`default_nettype none

module scp_div import scp_pkg::*; #(
  parameter int DW = 68,
  parameter int QW = SCP_FRAC_BITS,
  parameter int SW = 8
) (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic [DW+QW-1:0]   num,
  input  wire logic [DW-1:0]      den,
  input  wire logic [SW-1:0]      side_in,
  output logic      [QW-1:0]      q,
  output logic      [SW-1:0]      side_out
);

  localparam int NW = DW + QW;

  logic [NW-1:0] num_r [QW-1];
  logic [DW-1:0] den_r [QW-1];
  logic [QW-1:0] q_r   [QW];
  logic [SW-1:0] sd_r  [QW];

  for (genvar i = 0; i < QW; i++) begin : g_stage
    localparam int BP = QW - 1 - i;
    logic [NW-1:0] num_in;
    logic [DW-1:0] den_in;
    logic [QW-1:0] q_in;
    logic [SW-1:0] sd_in;
    logic [NW-1:0] trial;
    logic          ge;

    if (i == 0) begin : g_first
      assign num_in = num;
      assign den_in = den;
      assign q_in   = '0;
      assign sd_in  = side_in;
    end else begin : g_next
      assign num_in = num_r[i-1];
      assign den_in = den_r[i-1];
      assign q_in   = q_r[i-1];
      assign sd_in  = sd_r[i-1];
    end

    assign trial = NW'(den_in) << BP;
    assign ge    = (num_in >= trial);

    if (i < QW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          num_r[i] <= ge ? (num_in - trial) : num_in;
          den_r[i] <= den_in;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[i]  <= q_in | (QW'(ge) << BP);
        sd_r[i] <= sd_in;
      end
    end
  end

  assign q        = q_r[QW-1];
  assign side_out = sd_r[QW-1];

endmodule

`default_nettype wire

FILE: rtl/segment_closest_points_unit.sv
// top level: closest point parameters between two 3d segments
// throughput: one request per cycle; the whole pipe advances whenever the output
//   register is empty or being taken, so a stall holds every stage in place
// reset clears only the valid bits and the output valid; data registers are not reset
`default_nettype none

module segment_closest_points_unit import scp_pkg::*; #(
  parameter int COORD_WIDTH = SCP_COORD_WIDTH,
  parameter int FRAC_BITS   = SCP_FRAC_BITS,
  localparam int IN_TDW     = ((12 * COORD_WIDTH + 7) / 8) * 8,
  localparam int OUT_TDW    = ((2 * (FRAC_BITS + 1) + 7) / 8) * 8
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // a_start_x, a_start_y, a_start_z, a_end_x, a_end_y, a_end_z,
  // b_start_x, b_start_y, b_start_z, b_end_x, b_end_y, b_end_z (low bits first)
  input  wire logic [IN_TDW-1:0]  in_tdata,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  // param_s, param_t (low bits first)
  output logic [OUT_TDW-1:0]      out_tdata,
  // parallel_flag
  output logic                    out_tuser,
  output logic                    out_tvalid,
  input  wire logic               out_tready
);

  localparam int CW    = COORD_WIDTH;
  localparam int F     = FRAC_BITS;
  localparam int DFW   = CW + 1;                 // coordinate difference
  localparam int PRW   = 2 * DFW;                // one product term
  localparam int DOTW  = PRW + 2;                // dot product
  localparam int NMUL  = (DOTW + SCP_MUL_CHUNK - 1) / SCP_MUL_CHUNK;
  localparam int PW    = 2 * DOTW;               // product of two dot products
  localparam int DENW  = PW + 1;                 // denominator and s numerator
  localparam int SRW   = DOTW + F + 2;           // s times r
  localparam int NTW   = DOTW + F + 3;           // t numerator
  localparam int SW1   = 3 + 5 * DOTW;
  localparam int SW2   = F + 5;
  localparam int NPIPE = 9 + NMUL + 2 * F;
  localparam logic [F:0] ONE_Q = (F+1)'(1) << F;

  // pipe advances when the output slot is free or being drained
  logic adv;
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  logic [NPIPE-1:0] vld_r;
  logic             out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[NPIPE-2:0], in_tvalid};
      out_valid_r <= vld_r[NPIPE-1];
    end
  end

  // stage 1: edge vectors
  logic signed [CW-1:0]  fld [12];
  logic signed [DFW-1:0] e1_r [3];
  logic signed [DFW-1:0] e2_r [3];
  logic signed [DFW-1:0] e12_r [3];

  for (genvar i = 0; i < 12; i++) begin : g_fld
    assign fld[i] = in_tdata[i*CW +: CW];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        e1_r[k]  <= DFW'(fld[3+k]) - DFW'(fld[k]);
        e2_r[k]  <= DFW'(fld[9+k]) - DFW'(fld[6+k]);
        e12_r[k] <= DFW'(fld[6+k]) - DFW'(fld[k]);
      end
    end
  end

  // stage 2: the fifteen product terms
  logic signed [PRW-1:0] pd1_r [3];
  logic signed [PRW-1:0] pd2_r [3];
  logic signed [PRW-1:0] ps1_r [3];
  logic signed [PRW-1:0] ps2_r [3];
  logic signed [PRW-1:0] pr_r  [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        pd1_r[k] <= e1_r[k] * e1_r[k];
        pd2_r[k] <= e2_r[k] * e2_r[k];
        ps1_r[k] <= e1_r[k] * e12_r[k];
        ps2_r[k] <= e2_r[k] * e12_r[k];
        pr_r[k]  <= e1_r[k] * e2_r[k];
      end
    end
  end

  // stage 3: dot products
  logic signed [DOTW-1:0] d1_r, d2_r, s1_r, s2_r, r_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      d1_r <= DOTW'(pd1_r[0]) + DOTW'(pd1_r[1]) + DOTW'(pd1_r[2]);
      d2_r <= DOTW'(pd2_r[0]) + DOTW'(pd2_r[1]) + DOTW'(pd2_r[2]);
      s1_r <= DOTW'(ps1_r[0]) + DOTW'(ps1_r[1]) + DOTW'(ps1_r[2]);
      s2_r <= DOTW'(ps2_r[0]) + DOTW'(ps2_r[1]) + DOTW'(ps2_r[2]);
      r_r  <= DOTW'(pr_r[0])  + DOTW'(pr_r[1])  + DOTW'(pr_r[2]);
    end
  end

  // multiplier stages: d1*d2, r*r, s1*d2, s2*r
  logic signed [PW-1:0] d1d2, rr, s1d2, s2r;

  scp_mul #(.AW(DOTW), .BW(DOTW), .CHW(SCP_MUL_CHUNK)) u_mul_d1d2 (
    .clk(clk), .en(adv), .a(d1_r), .b(d2_r), .p(d1d2)
  );
  scp_mul #(.AW(DOTW), .BW(DOTW), .CHW(SCP_MUL_CHUNK)) u_mul_rr (
    .clk(clk), .en(adv), .a(r_r), .b(r_r), .p(rr)
  );
  scp_mul #(.AW(DOTW), .BW(DOTW), .CHW(SCP_MUL_CHUNK)) u_mul_s1d2 (
    .clk(clk), .en(adv), .a(s1_r), .b(d2_r), .p(s1d2)
  );
  scp_mul #(.AW(DOTW), .BW(DOTW), .CHW(SCP_MUL_CHUNK)) u_mul_s2r (
    .clk(clk), .en(adv), .a(s2_r), .b(r_r), .p(s2r)
  );

  // dot products ride alongside the multipliers
  logic signed [DOTW-1:0] dl_d1_r [NMUL];
  logic signed [DOTW-1:0] dl_d2_r [NMUL];
  logic signed [DOTW-1:0] dl_s1_r [NMUL];
  logic signed [DOTW-1:0] dl_s2_r [NMUL];
  logic signed [DOTW-1:0] dl_r_r  [NMUL];

  always_ff @(posedge clk) begin
    if (adv) begin
      dl_d1_r[0] <= d1_r;
      dl_d2_r[0] <= d2_r;
      dl_s1_r[0] <= s1_r;
      dl_s2_r[0] <= s2_r;
      dl_r_r[0]  <= r_r;
      for (int k = 1; k < NMUL; k++) begin
        dl_d1_r[k] <= dl_d1_r[k-1];
        dl_d2_r[k] <= dl_d2_r[k-1];
        dl_s1_r[k] <= dl_s1_r[k-1];
        dl_s2_r[k] <= dl_s2_r[k-1];
        dl_r_r[k]  <= dl_r_r[k-1];
      end
    end
  end

  // denominator and s numerator
  logic signed [DENW-1:0] den_r, ns_r;
  logic signed [DOTW-1:0] q_d1_r, q_d2_r, q_s1_r, q_s2_r, q_r_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      den_r  <= DENW'(d1d2) - DENW'(rr);
      ns_r   <= DENW'(s1d2) - DENW'(s2r);
      q_d1_r <= dl_d1_r[NMUL-1];
      q_d2_r <= dl_d2_r[NMUL-1];
      q_s1_r <= dl_s1_r[NMUL-1];
      q_s2_r <= dl_s2_r[NMUL-1];
      q_r_r  <= dl_r_r[NMUL-1];
    end
  end

  // parallel test and clamp of the s ratio
  logic                  c_par_r, c_sz_r, c_so_r;
  logic [DENW+F-1:0]     c_num_r;
  logic [DENW-1:0]       c_den_r;
  logic [5*DOTW-1:0]     c_side_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      c_par_r  <= den_r[DENW-1] || (den_r == '0);
      c_sz_r   <= ns_r[DENW-1] || (ns_r == '0);
      c_so_r   <= (ns_r >= den_r);
      c_num_r  <= {ns_r, {F{1'b0}}};
      c_den_r  <= den_r;
      c_side_r <= {q_d1_r, q_d2_r, q_s1_r, q_s2_r, q_r_r};
    end
  end

  logic [F-1:0]   q1;
  logic [SW1-1:0] side1;

  scp_div #(.DW(DENW), .QW(F), .SW(SW1)) u_div_s (
    .clk(clk), .en(adv), .num(c_num_r), .den(c_den_r),
    .side_in({c_par_r, c_sz_r, c_so_r, c_side_r}),
    .q(q1), .side_out(side1)
  );

  // unpack sideband after the s divider
  logic                   u_par, u_sz, u_so;
  logic signed [DOTW-1:0] u_d1, u_d2, u_s1, u_s2, u_r;
  logic [F:0]             s_val;
  logic signed [F+1:0]    s_sg;

  assign u_par = side1[SW1-1];
  assign u_sz  = side1[SW1-2];
  assign u_so  = side1[SW1-3];
  assign u_d1  = side1[4*DOTW +: DOTW];
  assign u_d2  = side1[3*DOTW +: DOTW];
  assign u_s1  = side1[2*DOTW +: DOTW];
  assign u_s2  = side1[DOTW +: DOTW];
  assign u_r   = side1[0 +: DOTW];

  always_comb begin
    if (u_par || u_sz) begin
      s_val = '0;
    end else if (u_so) begin
      s_val = ONE_Q;
    end else begin
      s_val = {1'b0, q1};
    end
  end
  assign s_sg = {1'b0, s_val};

  // s times r
  logic signed [SRW-1:0]  m_sr_r;
  logic [F:0]             m_s_r;
  logic                   m_par_r;
  logic signed [DOTW-1:0] m_d1_r, m_d2_r, m_s1_r, m_s2_r, m_r_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      m_sr_r  <= s_sg * u_r;
      m_s_r   <= s_val;
      m_par_r <= u_par;
      m_d1_r  <= u_d1;
      m_d2_r  <= u_d2;
      m_s1_r  <= u_s1;
      m_s2_r  <= u_s2;
      m_r_r   <= u_r;
    end
  end

  // t numerator, scaled by one
  logic signed [NTW-1:0]  n_nt_r;
  logic [F:0]             n_s_r;
  logic                   n_par_r;
  logic signed [DOTW-1:0] n_d1_r, n_d2_r, n_s1_r, n_s2_r, n_r_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      n_nt_r  <= NTW'(m_sr_r) - (NTW'(m_s2_r) <<< F);
      n_s_r   <= m_s_r;
      n_par_r <= m_par_r;
      n_d1_r  <= m_d1_r;
      n_d2_r  <= m_d2_r;
      n_s1_r  <= m_s1_r;
      n_s2_r  <= m_s2_r;
      n_r_r   <= m_r_r;
    end
  end

  // branch select: which ratio feeds the last divider
  logic signed [NTW-1:0]  dfull;
  scp_kind_t              x_kind_nxt, x_kind_r;
  logic                   x_tos_nxt, x_tos_r;
  logic [F:0]             x_oth_nxt, x_oth_r;
  logic signed [DOTW:0]   x_num_nxt, x_num_r;
  logic [DOTW-1:0]        x_den_nxt, x_den_r;
  logic [DOTW+F-1:0]      x_raw_r;
  logic                   x_par_r;

  assign dfull = NTW'(n_d2_r) <<< F;

  always_comb begin
    x_kind_nxt = KIND_RATIO;
    x_tos_nxt  = 1'b1;
    x_oth_nxt  = '0;
    x_num_nxt  = (DOTW+1)'(n_s1_r);
    x_den_nxt  = n_d1_r[DOTW-1:0];
    if (n_par_r) begin
      // parallel: s is zero, t is the clamped projection
      x_tos_nxt = 1'b0;
      x_oth_nxt = '0;
      x_num_nxt = -(DOTW+1)'(n_s2_r);
      x_den_nxt = n_d2_r[DOTW-1:0];
      if (n_d2_r == '0) begin
        x_kind_nxt = KIND_ZERO;
      end
    end else if (n_nt_r[NTW-1]) begin
      // t below zero: recompute s against the start of the second segment
      x_oth_nxt = '0;
    end else if (n_nt_r > dfull) begin
      // t above one: recompute s against its end
      x_oth_nxt = ONE_Q;
      x_num_nxt = (DOTW+1)'(n_r_r) + (DOTW+1)'(n_s1_r);
    end else if (n_nt_r == dfull) begin
      x_kind_nxt = KIND_ONE;
      x_tos_nxt  = 1'b0;
      x_oth_nxt  = n_s_r;
    end else begin
      x_kind_nxt = KIND_RAW;
      x_tos_nxt  = 1'b0;
      x_oth_nxt  = n_s_r;
      x_den_nxt  = n_d2_r[DOTW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x_kind_r <= x_kind_nxt;
      x_tos_r  <= x_tos_nxt;
      x_oth_r  <= x_oth_nxt;
      x_num_r  <= x_num_nxt;
      x_den_r  <= x_den_nxt;
      x_raw_r  <= n_nt_r[DOTW+F-1:0];
      x_par_r  <= n_par_r;
    end
  end

  // clamp of the selected ratio
  scp_kind_t         y_kind_nxt, y_kind_r;
  logic [DOTW+F-1:0] y_raw_nxt, y_raw_r;
  logic [DOTW-1:0]   y_den_r;
  logic [F+2:0]      y_side_r;

  always_comb begin
    y_kind_nxt = x_kind_r;
    y_raw_nxt  = x_raw_r;
    case (x_kind_r)
      KIND_RATIO: begin
        if (x_num_r[DOTW] || (x_num_r == '0)) begin
          y_kind_nxt = KIND_ZERO;
        end else if (x_num_r >= $signed({1'b0, x_den_r})) begin
          y_kind_nxt = KIND_ONE;
        end else begin
          y_kind_nxt = KIND_RAW;
          y_raw_nxt  = {x_num_r[DOTW-1:0], {F{1'b0}}};
        end
      end
      default: begin
        y_kind_nxt = x_kind_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      y_kind_r <= y_kind_nxt;
      y_raw_r  <= y_raw_nxt;
      y_den_r  <= x_den_r;
      y_side_r <= {x_par_r, x_tos_r, x_oth_r};
    end
  end

  logic [F-1:0]   q2;
  logic [SW2-1:0] side2;

  scp_div #(.DW(DOTW), .QW(F), .SW(SW2)) u_div_t (
    .clk(clk), .en(adv), .num(y_raw_r), .den(y_den_r),
    .side_in({y_side_r, y_kind_r}),
    .q(q2), .side_out(side2)
  );

  // final assembly into the output register
  scp_kind_t  f_kind;
  logic       f_par, f_tos;
  logic [F:0] f_oth, f_q, f_s, f_t;

  assign f_par  = side2[SW2-1];
  assign f_tos  = side2[SW2-2];
  assign f_oth  = side2[2 +: F+1];
  assign f_kind = scp_kind_t'(side2[1:0]);

  always_comb begin
    case (f_kind)
      KIND_ZERO: f_q = '0;
      KIND_ONE:  f_q = ONE_Q;
      default:   f_q = {1'b0, q2};
    endcase
    f_s = f_tos ? f_q : f_oth;
    f_t = f_tos ? f_oth : f_q;
  end

  logic [OUT_TDW-1:0] out_tdata_r;
  logic               out_tuser_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      out_tdata_r <= OUT_TDW'({f_t, f_s});
      out_tuser_r <= f_par;
    end
  end

  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_tvalid = out_valid_r;

  // checks
  a_s_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[F:0] <= ONE_Q))
    else $error("param_s above one");

  a_t_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[2*F+1:F+1] <= ONE_Q))
    else $error("param_t above one");

  a_par_s_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata[F:0] == '0))
    else $error("parallel result with nonzero s");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> ($stable(vld_r) && out_tvalid))
    else $error("pipeline moved during stall");

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
// testbench for segment_closest_points_unit: closest point parameters of segment pairs
`timescale 1ns / 1ps

module tb_top;
  import scp_pkg::*;

  localparam int CW       = SCP_COORD_WIDTH;
  localparam int FB       = SCP_FRAC_BITS;
  localparam int IN_TDW   = ((12 * CW + 7) / 8) * 8;
  localparam int OUT_TDW  = ((2 * (FB + 1) + 7) / 8) * 8;
  localparam int N_RANDOM = 1540;
  // generous slack beyond the pipeline depth, for the drain at the end
  localparam int DRAIN    = 120;
  // cycles without any handshake before the run is given up
  localparam int STALL_LIMIT = 5000;
  localparam logic [FB:0] ONE_Q = (FB+1)'(1) << FB;

  // wide enough for every exact intermediate (about 150 bits of magnitude)
  typedef logic signed [255:0] wide_t;

  typedef logic [11:0][CW-1:0] seg_pair_t;

  typedef struct packed {
    logic [FB:0] s;
    logic [FB:0] t;
    logic        par;
  } params_t;

  typedef struct {
    int      c [12];
    bit      typed;
    params_t exp;
  } dir_row_t;

  logic                clk;
  logic                rst_n;
  logic [IN_TDW-1:0]   in_tdata;
  logic                in_tvalid;
  logic                in_tready;
  logic [OUT_TDW-1:0]  out_tdata;
  logic                out_tuser;
  logic                out_tvalid;
  logic                out_tready;

  params_t     pending_params [$];
  int          errors;
  int          n_requests;
  int          n_results;
  int          n_parallel;
  int          n_clamped;
  int          idle_cycles;
  bit          hold_done;

  segment_closest_points_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // sign-extended coordinate k of a request
  function automatic wide_t coord(seg_pair_t p, int k);
    logic signed [CW-1:0] v;
    v = p[k];
    return wide_t'(v);
  endfunction

  // clamp01(num/den) in Q1.FB, truncated; den > 0
  function automatic logic [FB:0] clamp_quot(wide_t num, wide_t den);
    wide_t q;
    if (num <= 0) return '0;
    if (num >= den) return ONE_Q;
    q = (num <<< FB) / den;
    return q[FB:0];
  endfunction

  // exact closest point parameters for one segment pair
  function automatic params_t closest_params(seg_pair_t p);
    wide_t   e1 [3];
    wide_t   e2 [3];
    wide_t   e12 [3];
    wide_t   d1, d2, s1, s2, r, den, ns, nt, dfull, q;
    params_t res;
    d1 = 0; d2 = 0; s1 = 0; s2 = 0; r = 0;
    for (int k = 0; k < 3; k++) begin
      e1[k]  = coord(p, 3 + k) - coord(p, k);
      e2[k]  = coord(p, 9 + k) - coord(p, 6 + k);
      e12[k] = coord(p, 6 + k) - coord(p, k);
      d1 += e1[k] * e1[k];
      d2 += e2[k] * e2[k];
      s1 += e1[k] * e12[k];
      s2 += e2[k] * e12[k];
      r  += e1[k] * e2[k];
    end
    den = d1 * d2 - r * r;
    res.par = 1'b0;
    if (den <= 0) begin
      // parallel or degenerate: s pinned to the first segment start
      res.par = 1'b1;
      res.s   = '0;
      res.t   = (d2 == 0) ? '0 : clamp_quot(-s2, d2);
    end else begin
      ns    = s1 * d2 - s2 * r;
      res.s = clamp_quot(ns, den);
      nt    = wide_t'({1'b0, res.s}) * r - (s2 <<< FB);
      dfull = d2 <<< FB;
      if (nt < 0) begin
        // t clamps low, so s is redone against the second segment start
        res.t = '0;
        res.s = clamp_quot(s1, d1);
      end else if (nt > dfull) begin
        // t clamps high, s is redone against the second segment end
        res.t = ONE_Q;
        res.s = clamp_quot(r + s1, d1);
      end else if (nt == dfull) begin
        res.t = ONE_Q;
      end else begin
        q     = nt / d2;
        res.t = q[FB:0];
      end
    end
    return res;
  endfunction

  // random segment pair, partly shaped to hit the interesting branches
  function automatic seg_pair_t rand_pair();
    seg_pair_t p;
    int        kind;
    int        m;
    kind = $urandom_range(0, 9);
    for (int k = 0; k < 12; k++) begin
      if (kind <= 2) p[k] = $urandom();
      else p[k] = $urandom_range(0, 1 << 21) - (1 << 20);
    end
    case (kind)
      6: begin
        // second segment along a multiple of the first direction
        m = $urandom_range(0, 6) - 3;
        for (int k = 0; k < 3; k++) p[9 + k] = p[6 + k] + m * (p[3 + k] - p[k]);
      end
      7: begin
        // one segment collapsed to a point
        if ($urandom_range(0, 1) != 0) for (int k = 0; k < 3; k++) p[3 + k] = p[k];
        else for (int k = 0; k < 3; k++) p[9 + k] = p[6 + k];
      end
      8: begin
        // collinear segments sharing one line
        m = $urandom_range(0, 4) - 2;
        for (int k = 0; k < 3; k++) begin
          p[6 + k] = p[k] + m * (p[3 + k] - p[k]);
          p[9 + k] = p[6 + k] + (p[3 + k] - p[k]);
        end
      end
      9: begin
        // coordinates pushed far out by flipping one of their top two bits, chosen per coordinate
        for (int k = 0; k < 12; k++) p[k] = {$urandom_range(0, 1) ? 2'b10 : 2'b01, 30'h0} ^ p[k];
      end
      default: ;
    endcase
    return p;
  endfunction

  // directed requests; typed results are the ones obvious by inspection
  dir_row_t dir_rows [11];

  function automatic void load_dir_rows();
    int unsigned mx, mn, one, mone;
    mx = 32'h7FFFFFFF; mn = 32'h80000000; one = 32'h10000; mone = 32'hFFFF0000;
    // all points at the origin
    dir_rows[0] = '{'{0,0,0, 0,0,0, 0,0,0, 0,0,0}, 1'b1, '{17'd0, 17'd0, 1'b1}};
    // perpendicular skew segments, closest at their midpoints
    dir_rows[1] = '{'{mone,0,0, one,0,0, 0,mone,one, 0,one,one}, 1'b1,
                    '{17'd32768, 17'd32768, 1'b0}};
    // full-range diagonal against its own reverse
    dir_rows[2] = '{'{mn,mn,mn, mx,mx,mx, mx,mx,mx, mn,mn,mn}, 1'b1, '{17'd0, ONE_Q, 1'b1}};
    // zero-length second segment
    dir_rows[3] = '{'{0,0,0, one,one,one, mx,mn,0, mx,mn,0}, 1'b1, '{17'd0, 17'd0, 1'b1}};
    // zero-length first segment
    dir_rows[4] = '{'{one,one,0, one,one,0, 0,0,0, 0,2*one,one}, 1'b0, '{17'd0, 17'd0, 1'b0}};
    // t clamps low
    dir_rows[5] = '{'{0,0,0, one,0,0, 2*one,one,0, 3*one,2*one,one}, 1'b0,
                    '{17'd0, 17'd0, 1'b0}};
    // t clamps high
    dir_rows[6] = '{'{0,0,0, one,0,0, mone*3,mone*2,one, mone*2,mone,one}, 1'b0,
                    '{17'd0, 17'd0, 1'b0}};
    // t lands exactly on the second segment end
    dir_rows[7] = '{'{0,0,0, 2*one,0,0, one,mone,one, one,0,one}, 1'b0, '{17'd0, 17'd0, 1'b0}};
    // extremes mixed across fields
    dir_rows[8] = '{'{mx,mn,mx, mn,mx,mn, mn,mn,mx, mx,mx,mn}, 1'b0, '{17'd0, 17'd0, 1'b0}};
    dir_rows[9] = '{'{mx,mx,mx, mx,mx,mx, mn,mn,mn, mx,mn,mx}, 1'b0, '{17'd0, 17'd0, 1'b0}};
    // skew segments with fractional answer
    dir_rows[10] = '{'{0,0,0, 3*one,0,0, one,mone,one, 2*one,2*one,mone}, 1'b0,
                     '{17'd0, 17'd0, 1'b0}};
  endfunction

  // request side: bursts with random gaps, two drain pauses
  initial begin
    seg_pair_t p;
    params_t   want;
    int        burst;
    int        n_total;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    rst_n      = 1'b0;
    errors     = 0;
    n_requests = 0;
    n_results  = 0;
    n_parallel = 0;
    n_clamped  = 0;
    load_dir_rows();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    n_total = $size(dir_rows) + N_RANDOM;
    burst = $urandom_range(1, 40);
    for (int i = 0; i < n_total; i++) begin
      if (i < $size(dir_rows)) begin
        for (int k = 0; k < 12; k++) p[k] = dir_rows[i].c[k];
        want = dir_rows[i].typed ? dir_rows[i].exp : closest_params(p);
      end else begin
        p    = rand_pair();
        want = closest_params(p);
      end
      // let everything drain after the directed rows and once mid-run
      if (i == $size(dir_rows) || i == 800) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_params.size() != 0) @(posedge clk);
      end
      in_tdata  <= p;
      in_tvalid <= 1'b1;
      @(posedge clk);
      while (!in_tready) @(posedge clk);
      pending_params.insert(pending_params.size(), want);
      n_requests++;
      if (want.par) n_parallel++;
      if (!want.par && (want.t == 0 || want.t == ONE_Q)) n_clamped++;
      burst--;
      if (burst == 0) begin
        burst = $urandom_range(1, 40);
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
    in_tvalid <= 1'b0;
    while (pending_params.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    $display("covered %0d requests, %0d results: %0d parallel or degenerate, %0d with t clamped",
             n_requests, n_results, n_parallel, n_clamped);
    if (errors == 0) begin
      $display("** segment_closest_points_unit: PASSED **");
    end else begin
      $display("** segment_closest_points_unit: FAILED **");
    end
    $finish;
  end

  // result side: stall pattern changes every so often, one long hold mid-run
  initial begin
    int pattern;
    int span;
    out_tready = 1'b0;
    hold_done  = 1'b0;
    @(posedge rst_n);
    forever begin
      if (!hold_done && n_requests > 400) begin
        // long hold so the pipe fills up and backs up the request side
        hold_done = 1'b1;
        out_tready <= 1'b0;
        repeat (300) @(posedge clk);
      end
      pattern = $urandom_range(0, 3);
      span    = $urandom_range(20, 150);
      repeat (span) begin
        case (pattern)
          0:       out_tready <= 1'b1;
          1:       out_tready <= ($urandom_range(0, 3) != 0);
          2:       out_tready <= ($urandom_range(0, 3) == 0);
          default: out_tready <= $urandom_range(0, 1);
        endcase
        @(posedge clk);
      end
    end
  end

  // result checker: compare every accepted result with the oldest prediction
  always @(posedge clk) begin
    params_t want;
    params_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.s   = out_tdata[FB:0];
      got.t   = out_tdata[2*FB+1:FB+1];
      got.par = out_tuser;
      n_results++;
      if (pending_params.size() == 0) begin
        errors++;
        $display("%0t: result with nothing pending: s=%0d t=%0d par=%0b",
                 $time, got.s, got.t, got.par);
      end else begin
        want = pending_params.pop_front();
        if (got.s !== want.s) begin
          errors++;
          $display("%0t: param_s expected %0d got %0d", $time, want.s, got.s);
        end
        if (got.t !== want.t) begin
          errors++;
          $display("%0t: param_t expected %0d got %0d", $time, want.t, got.t);
        end
        if (got.par !== want.par) begin
          errors++;
          $display("%0t: parallel_flag expected %0b got %0b", $time, want.par, got.par);
        end
      end
    end
  end

  // watchdog: no handshake on either side for too long ends the run
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles, %0d results outstanding",
                 $time, STALL_LIMIT, pending_params.size());
        $display("** segment_closest_points_unit: FAILED **");
        $finish;
      end
    end
  end

endmodule

FILE: sim.f
rtl/scp_pkg.sv
rtl/scp_mul.sv
rtl/scp_div.sv
rtl/segment_closest_points_unit.sv
dv/tb_top.sv
